FILE: src/mhle_pkg.sv
// Maidenhead locator encoder: shared types, constants, digit split and size rounding functions.
// No dependencies; imported by every module of the block.
`default_nettype none

package mhle_pkg;

    // Field widths of the stream words
    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 4;
    localparam int NUM_CHARS = 10;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;

    // Pipeline depth: input, offset, four split levels, output
    localparam int NUM_STAGES = 7;

    // Stage numbers
    localparam int ST_IN  = 0;
    localparam int ST_OFS = 1;
    localparam int ST_L1  = 2;
    localparam int ST_L2  = 3;
    localparam int ST_L3  = 4;
    localparam int ST_L4  = 5;
    localparam int ST_OUT = 6;

    // Coordinate limits in millionths of a degree
    localparam logic signed [LAT_W-1:0] LAT_LIMIT = 28'sd90000000;
    localparam logic signed [LON_W-1:0] LON_LIMIT = 29'sd180000000;

    // Divisors per level
    localparam logic [24:0] LON_FIELD_DIV = 25'd20000000;
    localparam logic [24:0] LAT_FIELD_DIV = 25'd10000000;
    localparam logic [24:0] LON_SQ_DIV    = 25'd2000000;
    localparam logic [24:0] LAT_SQ_DIV    = 25'd1000000;
    localparam logic [24:0] LON_SUB_DIV   = 25'd250000;
    localparam logic [24:0] LAT_SUB_DIV   = 25'd125000;
    localparam logic [24:0] LON_EXT_DIV   = 25'd25000;
    localparam logic [24:0] LAT_EXT_DIV   = 25'd12500;
    localparam logic [24:0] SUB2_DIV      = 25'd3125;

    // Highest quotient per level
    localparam logic [4:0] FIELD_KMAX = 5'd18;
    localparam logic [4:0] DEC_KMAX   = 5'd9;
    localparam logic [4:0] SUB_KMAX   = 5'd23;

    // ASCII bases
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;

    // Locator lengths
    localparam logic [COUNT_W-1:0] LEN_0  = 4'd0;
    localparam logic [COUNT_W-1:0] LEN_4  = 4'd4;
    localparam logic [COUNT_W-1:0] LEN_6  = 4'd6;
    localparam logic [COUNT_W-1:0] LEN_8  = 4'd8;
    localparam logic [COUNT_W-1:0] LEN_10 = 4'd10;
    localparam logic [COUNT_W-1:0] SIZE_RESET = 4'd6;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    // One result word; char 0 ends up in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]                  char_count;
        logic [NUM_CHARS-1:0][CHAR_W-1:0]    chars;
    } result_t;

    typedef struct packed {
        logic [4:0]  q;
        logic [28:0] r;
    } split_t;

    // Quotient and remainder of v by a constant d, by parallel trial
    // subtraction of every multiple up to kmax
    function automatic split_t split_digit(input logic [28:0] v,
                                           input logic [24:0] d,
                                           input logic [4:0]  kmax);
        logic [33:0] mult;
        split_t      res;
        res.q = 5'd0;
        res.r = v;
        for (int k = 1; k < 24; k++) begin
            mult = 34'(k) * 34'(d);
            if ((5'(k) <= kmax) && ({5'd0, v} >= mult)) begin
                res.q = 5'(k);
                res.r = v - mult[28:0];
            end
        end
        return res;
    endfunction

    // Requested size rounded down to a supported locator length
    function automatic logic [COUNT_W-1:0] size_to_count(input logic [COUNT_W-1:0] size);
        logic [COUNT_W-1:0] cnt;
        if (size >= LEN_10)     cnt = LEN_10;
        else if (size >= LEN_8) cnt = LEN_8;
        else if (size >= LEN_6) cnt = LEN_6;
        else if (size >= LEN_4) cnt = LEN_4;
        else                    cnt = LEN_0;
        return cnt;
    endfunction

endpackage

`default_nettype wire

FILE: src/mhle_pipe_ctrl.sv
// Maidenhead locator encoder: per-stage valid bits and stall control.
// Depends on mhle_pkg.
`default_nettype none

module mhle_pipe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mhle_pkg::pipe_ctl_t ctl,
    output logic [mhle_pkg::NUM_STAGES-1:0] stage_valid
);
    import mhle_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] go;
    logic [NUM_STAGES-1:0] ready;

    // Ready ripples back from the output; a stage may load when empty
    // or when its word moves on in the same cycle
    always_comb begin
        go[NUM_STAGES-1]    = valid_reg[NUM_STAGES-1] && m_tready;
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || go[NUM_STAGES-1];
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            go[i]    = valid_reg[i] && ready[i+1];
            ready[i] = !valid_reg[i] || go[i];
        end
        ctl.load[0] = s_tvalid && ready[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            ctl.load[i] = go[i-1];
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            valid_next[i] = ctl.load[i] || (valid_reg[i] && !go[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready    = ready[0];
    assign m_tvalid    = valid_reg[NUM_STAGES-1];
    assign stage_valid = valid_reg;

endmodule

`default_nettype wire

FILE: src/mhle_datapath.sv
// Maidenhead locator encoder: clamp/offset, digit split levels, output register.
// Depends on mhle_pkg; load enables come from mhle_pipe_ctrl.
`default_nettype none

module mhle_datapath (
    input  logic                                  aclk,
    input  mhle_pkg::pipe_ctl_t                   ctl,
    input  logic [mhle_pkg::LAT_W-1:0]            lat_in,
    input  logic [mhle_pkg::LON_W-1:0]            lon_in,
    input  logic [mhle_pkg::COUNT_W-1:0]          char_count,
    output mhle_pkg::result_t                     result
);
    import mhle_pkg::*;

    typedef logic [NUM_CHARS-1:0][4:0] digits_t;

    // Input register
    logic [LAT_W-1:0] lat_raw_reg;
    logic [LON_W-1:0] lon_raw_reg;

    // Offset coordinates
    logic [LAT_W-1:0] ulat_reg, ulat_next;
    logic [LON_W-1:0] ulon_reg, ulon_next;

    // Remainders and digits after each split level
    logic [23:0] rlat1_reg, rlat1_next;
    logic [24:0] rlon1_reg, rlon1_next;
    logic [21:0] rlat2_reg, rlat2_next;
    logic [22:0] rlon2_reg, rlon2_next;
    logic [16:0] rlat3_reg, rlat3_next;
    logic [17:0] rlon3_reg, rlon3_next;
    logic [16:0] rlat4_reg, rlat4_next;
    logic [16:0] rlon4_reg, rlon4_next;
    digits_t     dig1_reg, dig1_next;
    digits_t     dig2_reg, dig2_next;
    digits_t     dig3_reg, dig3_next;
    digits_t     dig4_reg, dig4_next;

    result_t result_reg, result_next;

    logic signed [LAT_W-1:0] lat_clamp;
    logic signed [LON_W-1:0] lon_clamp;
    split_t sp_lat1, sp_lon1, sp_lat2, sp_lon2, sp_lat3, sp_lon3;
    split_t sp_lat4, sp_lon4, sp_lat5, sp_lon5;
    logic [19:0] rem_lat2;
    logic [20:0] rem_lon2;
    logic [13:0] rem_lat4;
    logic [14:0] rem_lon4;
    digits_t     dig5;
    logic [CHAR_W-1:0] base;

    // Saturate and shift into the positive range
    always_comb begin
        lat_clamp = signed'(lat_raw_reg);
        if (lat_clamp > LAT_LIMIT)       lat_clamp = LAT_LIMIT;
        else if (lat_clamp < -LAT_LIMIT) lat_clamp = -LAT_LIMIT;
        lon_clamp = signed'(lon_raw_reg);
        if (lon_clamp > LON_LIMIT)       lon_clamp = LON_LIMIT;
        else if (lon_clamp < -LON_LIMIT) lon_clamp = -LON_LIMIT;
        ulat_next = unsigned'(lat_clamp + LAT_LIMIT);
        ulon_next = unsigned'(lon_clamp + LON_LIMIT);
    end

    // Level 1: field (20 x 10 degrees)
    always_comb begin
        sp_lon1    = split_digit(29'(ulon_reg), LON_FIELD_DIV, FIELD_KMAX);
        sp_lat1    = split_digit(29'(ulat_reg), LAT_FIELD_DIV, FIELD_KMAX);
        dig1_next    = '0;
        dig1_next[0] = sp_lon1.q;
        dig1_next[1] = sp_lat1.q;
        rlon1_next   = sp_lon1.r[24:0];
        rlat1_next   = sp_lat1.r[23:0];
    end

    // Level 2: square (2 x 1 degrees), remainder scaled by 3
    always_comb begin
        sp_lon2      = split_digit(29'(rlon1_reg), LON_SQ_DIV, DEC_KMAX);
        sp_lat2      = split_digit(29'(rlat1_reg), LAT_SQ_DIV, DEC_KMAX);
        dig2_next    = dig1_reg;
        dig2_next[2] = sp_lon2.q;
        dig2_next[3] = sp_lat2.q;
        rem_lon2     = sp_lon2.r[20:0];
        rem_lat2     = sp_lat2.r[19:0];
        rlon2_next   = 23'(rem_lon2) + {1'b0, rem_lon2, 1'b0};
        rlat2_next   = 22'(rem_lat2) + {1'b0, rem_lat2, 1'b0};
    end

    // Level 3: subsquare
    always_comb begin
        sp_lon3      = split_digit(29'(rlon2_reg), LON_SUB_DIV, SUB_KMAX);
        sp_lat3      = split_digit(29'(rlat2_reg), LAT_SUB_DIV, SUB_KMAX);
        dig3_next    = dig2_reg;
        dig3_next[4] = sp_lon3.q;
        dig3_next[5] = sp_lat3.q;
        rlon3_next   = sp_lon3.r[17:0];
        rlat3_next   = sp_lat3.r[16:0];
    end

    // Level 4: extended square; longitude scaled by 3, latitude by 6
    always_comb begin
        sp_lon4      = split_digit(29'(rlon3_reg), LON_EXT_DIV, DEC_KMAX);
        sp_lat4      = split_digit(29'(rlat3_reg), LAT_EXT_DIV, DEC_KMAX);
        dig4_next    = dig3_reg;
        dig4_next[6] = sp_lon4.q;
        dig4_next[7] = sp_lat4.q;
        rem_lon4     = sp_lon4.r[14:0];
        rem_lat4     = sp_lat4.r[13:0];
        rlon4_next   = 17'(rem_lon4) + 17'({rem_lon4, 1'b0});
        rlat4_next   = 17'({rem_lat4, 2'b00}) + 17'({rem_lat4, 1'b0});
    end

    // Level 5: second subsquare, then ASCII and length masking
    always_comb begin
        sp_lon5  = split_digit(29'(rlon4_reg), SUB2_DIV, SUB_KMAX);
        sp_lat5  = split_digit(29'(rlat4_reg), SUB2_DIV, SUB_KMAX);
        dig5     = dig4_reg;
        dig5[8]  = sp_lon5.q;
        dig5[9]  = sp_lat5.q;
        result_next.char_count = char_count;
        for (int i = 0; i < NUM_CHARS; i++) begin
            case (i / 2)
                0:       base = ASCII_UPPER_A;
                1, 3:    base = ASCII_ZERO;
                default: base = ASCII_LOWER_A;
            endcase
            if (COUNT_W'(i) < char_count) begin
                result_next.chars[i] = base + CHAR_W'(dig5[i]);
            end else begin
                result_next.chars[i] = '0;
            end
        end
    end

    // Stage registers, each loaded when its word advances
    always_ff @(posedge aclk) begin
        if (ctl.load[ST_IN]) begin
            lat_raw_reg <= lat_in;
            lon_raw_reg <= lon_in;
        end
        if (ctl.load[ST_OFS]) begin
            ulat_reg <= ulat_next;
            ulon_reg <= ulon_next;
        end
        if (ctl.load[ST_L1]) begin
            rlat1_reg <= rlat1_next;
            rlon1_reg <= rlon1_next;
            dig1_reg  <= dig1_next;
        end
        if (ctl.load[ST_L2]) begin
            rlat2_reg <= rlat2_next;
            rlon2_reg <= rlon2_next;
            dig2_reg  <= dig2_next;
        end
        if (ctl.load[ST_L3]) begin
            rlat3_reg <= rlat3_next;
            rlon3_reg <= rlon3_next;
            dig3_reg  <= dig3_next;
        end
        if (ctl.load[ST_L4]) begin
            rlat4_reg <= rlat4_next;
            rlon4_reg <= rlon4_next;
            dig4_reg  <= dig4_next;
        end
        if (ctl.load[ST_OUT]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: src/maidenhead_locator_encoder.sv
// Maidenhead locator encoder, top level: size register, control and datapath.
// Depends on mhle_pkg, mhle_pipe_ctrl and mhle_datapath.
//
// Converts one latitude/longitude word (millionths of a degree) into an ASCII
// Maidenhead locator of 0, 4, 6, 8 or 10 characters. A new word is accepted
// every clock cycle while s_tready is high. Each word passes seven registers
// (input, clamp/offset, four split levels, output) before its result shows
// up on m_tvalid. Every stage has its own valid bit, so input is taken while
// a result waits as long as any stage is free. The size register should only be
// written while no word is in flight; values below 4 give an empty locator
// with all characters zero, values above 10 act as 10. Coordinates outside
// +/-90 and +/-180 degrees saturate; exactly +90 or +180 gives field letter S.
`default_nettype none

module maidenhead_locator_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Size register write
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    // Input position word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // latitude [27:0], longitude [56:28], zero [63:57]
    // Result locator word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // char_0..char_9 [69:0] 7 bits each, char_count [73:70]
);
    import mhle_pkg::*;

    logic [COUNT_W-1:0]    size_reg;
    logic [COUNT_W-1:0]    char_count;
    pipe_ctl_t             ctl;
    logic [NUM_STAGES-1:0] stage_valid;
    result_t               result;

    // Locator size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            size_reg <= cfg_wdata;
        end
    end

    assign char_count = size_to_count(size_reg);

    mhle_pipe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .ctl         (ctl),
        .stage_valid (stage_valid)
    );

    mhle_datapath u_dp (
        .aclk       (aclk),
        .ctl        (ctl),
        .lat_in     (s_tdata[LAT_W-1:0]),
        .lon_in     (s_tdata[LAT_W+LON_W-1:LAT_W]),
        .char_count (char_count),
        .result     (result)
    );

    assign m_tdata = {(M_TDATA_W - $bits(result_t))'(0), result};

    // Result length follows the size register
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[73:70] == char_count))
        else $error("char_count does not match locator size");

    // A full pipeline with the output stalled takes no new word
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((&stage_valid) && !m_tready) |-> !s_tready)
        else $error("input accepted with pipeline full");

    // Field letters stay within A..S when the locator is not empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[73:70] != LEN_0)) |->
        ((m_tdata[6:0] >= 7'd65) && (m_tdata[6:0] <= 7'd83) &&
         (m_tdata[13:7] >= 7'd65) && (m_tdata[13:7] <= 7'd83)))
        else $error("field letter out of range");

    // An empty locator carries only zero characters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[73:70] == LEN_0)) |-> (m_tdata[69:0] == 70'd0))
        else $error("empty locator carries characters");

endmodule

`default_nettype wire
